// ===== rtl/ahr_pkg.sv =====
`default_nettype none

package ahr_pkg;

  // Grid and cell table sizes
  localparam int GRID_SIDE  = 256;
  localparam int MAX_CELLS  = 65536;
  localparam int SLOT_COUNT = GRID_SIDE * GRID_SIDE;

  // Field widths
  localparam int IDX_W   = 16;
  localparam int COORD_W = 8;
  localparam int LEV_W   = 4;
  localparam int VAL_W   = 32;
  localparam int SUM_W   = VAL_W + 1;
  localparam int CSIZE_W = 9;

  // Derived widths
  localparam int SLOT_AW  = $clog2(SLOT_COUNT);
  localparam int CELL_AW  = $clog2(MAX_CELLS);
  localparam int FCOORD_W = $clog2(GRID_SIDE);
  localparam int FSIZE_W  = $clog2(GRID_SIDE + 1);
  localparam int WIDE_W   = CSIZE_W + (1 << LEV_W) - 1;
  localparam int SHIFT_W  = LEV_W + 1;

  // Register reset values
  localparam logic [CSIZE_W-1:0] COARSE_SIZE_RESET  = CSIZE_W'(16);
  localparam logic [LEV_W-1:0]   FINEST_LEVEL_RESET = LEV_W'(4);

  typedef logic [IDX_W-1:0]   idx_t;
  typedef logic [COORD_W-1:0] coord_t;
  typedef logic [LEV_W-1:0]   lev_t;
  typedef logic [VAL_W-1:0]   val_t;
  typedef logic [SUM_W-1:0]   sum_t;
  typedef logic [CSIZE_W-1:0] csize_t;
  typedef logic [SLOT_AW-1:0] slot_addr_t;
  typedef logic [CELL_AW-1:0] cell_addr_t;

  localparam sum_t SUM_MAX = '1;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_QUERY  = 1'b1
  } op_t;

  typedef enum logic [0:0] {
    REG_COARSE_SIZE  = 1'b0,
    REG_FINEST_LEVEL = 1'b1
  } cfg_reg_t;

  // Per-cell record: level and value
  typedef struct packed {
    lev_t level;
    val_t value;
  } cell_rec_t;

  typedef struct packed {
    logic       en;
    logic       we;
    slot_addr_t addr;
    cell_addr_t wdata;
  } slot_req_t;

  typedef struct packed {
    logic       en;
    logic       we;
    cell_addr_t addr;
    cell_rec_t  wdata;
  } cell_req_t;

  typedef struct packed {
    logic clear;
    logic add;
  } acc_ctl_t;

  typedef struct packed {
    logic valid;
    logic query;
    logic status;
  } res_t;

endpackage

`default_nettype wire

// ===== rtl/ahr_if.sv =====
`default_nettype none

// Item channel into the block
interface ahr_in_if;
  import ahr_pkg::*;
  logic   valid;
  logic   ready;
  logic   opcode;
  idx_t   cell_index;
  coord_t col;
  coord_t row;
  lev_t   level;
  val_t   cell_value;

  modport source (output valid, opcode, cell_index, col, row, level, cell_value,
                  input ready);
  modport sink   (input valid, opcode, cell_index, col, row, level, cell_value,
                  output ready);
endinterface

// Result channel out of the block
interface ahr_out_if;
  import ahr_pkg::*;
  logic valid;
  logic ready;
  sum_t remapped_sum;
  logic status;

  modport source (output valid, remapped_sum, status, input ready);
  modport sink   (input valid, remapped_sum, status, output ready);
endinterface

`default_nettype wire

// ===== rtl/ahr_slot_table.sv =====
`default_nettype none

module ahr_slot_table (
  input  wire                 clk,
  input  ahr_pkg::slot_req_t  req,
  output ahr_pkg::cell_addr_t rd_data
);
  import ahr_pkg::*;

  cell_addr_t mem [SLOT_COUNT];
  cell_addr_t rd_data_r;

  // Single port: write owner or read it back next cycle
  always_ff @(posedge clk) begin
    if (req.en) begin
      if (req.we) begin
        mem[req.addr] <= req.wdata;
      end else begin
        rd_data_r <= mem[req.addr];
      end
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

// ===== rtl/ahr_cell_store.sv =====
`default_nettype none

module ahr_cell_store (
  input  wire                clk,
  input  ahr_pkg::cell_req_t req,
  output ahr_pkg::cell_rec_t rd_data
);
  import ahr_pkg::*;

  cell_rec_t mem [MAX_CELLS];
  cell_rec_t rd_data_r;

  // Single port: write level and value, or read them back next cycle
  always_ff @(posedge clk) begin
    if (req.en) begin
      if (req.we) begin
        mem[req.addr] <= req.wdata;
      end else begin
        rd_data_r <= mem[req.addr];
      end
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

// ===== rtl/ahr_accum.sv =====
`default_nettype none

module ahr_accum (
  input  wire                clk,
  input  ahr_pkg::acc_ctl_t  ctl,
  input  ahr_pkg::lev_t      finest_level,
  input  ahr_pkg::cell_rec_t rec,
  output ahr_pkg::sum_t      sum
);
  import ahr_pkg::*;

  sum_t                      sum_r;
  sum_t                      sum_nxt;
  logic [SHIFT_W-1:0]        shamt;
  val_t                      contrib;
  logic [SUM_W:0]            wide;

  // Scale by the level gap; a stale level above finest adds the value whole.
  // The shift tops out at 30, so it never clears the whole word.
  always_comb begin
    if (rec.level <= finest_level) begin
      shamt = {finest_level - rec.level, 1'b0};
    end else begin
      shamt = '0;
    end
    contrib = rec.value >> shamt;
    wide    = {1'b0, sum_r} + (SUM_W + 1)'(contrib);
    sum_nxt = sum_r;
    if (ctl.clear) begin
      sum_nxt = '0;
    end else if (ctl.add) begin
      sum_nxt = wide[SUM_W] ? SUM_MAX : wide[SUM_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    sum_r <= sum_nxt;
  end

  assign sum = sum_r;

endmodule

`default_nettype wire

// ===== rtl/ahr_ctrl.sv =====
`default_nettype none

module ahr_ctrl (
  input  wire                 clk,
  input  wire                 rst_n,
  input  ahr_pkg::csize_t     coarse_size,
  input  ahr_pkg::lev_t       finest_level,
  // item side
  input  wire                 in_valid,
  output logic                in_ready,
  input  wire                 in_opcode,
  input  ahr_pkg::idx_t       in_cell_index,
  input  ahr_pkg::coord_t     in_col,
  input  ahr_pkg::coord_t     in_row,
  input  ahr_pkg::lev_t       in_level,
  input  ahr_pkg::val_t       in_cell_value,
  // memories and accumulator
  output ahr_pkg::slot_req_t  slot_req,
  input  ahr_pkg::cell_addr_t slot_rd_data,
  output ahr_pkg::cell_req_t  cell_req,
  output ahr_pkg::acc_ctl_t   acc_ctl,
  // result side
  input  wire                 out_free,
  output ahr_pkg::res_t       res
);
  import ahr_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SETUP,
    S_SCAN,
    S_DRAIN,
    S_FIN
  } state_t;

  state_t                 state_r, state_nxt;
  logic                   op_r, op_nxt;
  idx_t                   idx_r, idx_nxt;
  coord_t                 col_r, col_nxt;
  coord_t                 row_r, row_nxt;
  lev_t                   lev_r, lev_nxt;
  val_t                   val_r, val_nxt;
  logic                   status_r, status_nxt;
  logic [FSIZE_W-1:0]     fine_r, fine_nxt;
  logic [FCOORD_W-1:0]    span_m1_r, span_m1_nxt;
  logic [FCOORD_W-1:0]    c0_r, c0_nxt;
  slot_addr_t             row_base_r, row_base_nxt;
  logic [FCOORD_W-1:0]    col_cnt_r, col_cnt_nxt;
  logic [FCOORD_W-1:0]    row_cnt_r, row_cnt_nxt;
  logic                   v1_r, v1_nxt;
  logic                   v2_r, v2_nxt;

  logic [WIDE_W-1:0]      fine_w, own_w, span_w, c0_w, r0_w;
  lev_t                   diff;
  logic                   err;
  logic [FCOORD_W+FSIZE_W-1:0] prod;

  // Geometry of the held item against the current grid
  always_comb begin
    fine_w = WIDE_W'(coarse_size) << finest_level;
    own_w  = WIDE_W'(coarse_size) << lev_r;
    diff   = finest_level - lev_r;
    span_w = WIDE_W'(1) << diff;
    c0_w   = WIDE_W'(col_r) << diff;
    r0_w   = WIDE_W'(row_r) << diff;
    err    = (fine_w == '0) || (fine_w > WIDE_W'(GRID_SIDE)) ||
             (lev_r > finest_level) ||
             (WIDE_W'(col_r) >= own_w) || (WIDE_W'(row_r) >= own_w) ||
             ((op_r == OP_INSERT) && (32'(idx_r) >= 32'(MAX_CELLS)));
    prod   = (FCOORD_W + FSIZE_W)'(FCOORD_W'(r0_w)) *
             (FCOORD_W + FSIZE_W)'(FSIZE_W'(fine_w));
  end

  // Sequencer
  always_comb begin
    state_nxt    = state_r;
    op_nxt       = op_r;
    idx_nxt      = idx_r;
    col_nxt      = col_r;
    row_nxt      = row_r;
    lev_nxt      = lev_r;
    val_nxt      = val_r;
    status_nxt   = status_r;
    fine_nxt     = fine_r;
    span_m1_nxt  = span_m1_r;
    c0_nxt       = c0_r;
    row_base_nxt = row_base_r;
    col_cnt_nxt  = col_cnt_r;
    row_cnt_nxt  = row_cnt_r;
    v1_nxt       = 1'b0;
    v2_nxt       = v1_r;

    in_ready = (state_r == S_IDLE);

    slot_req       = '0;
    slot_req.addr  = row_base_r + SLOT_AW'(c0_r) + SLOT_AW'(col_cnt_r);
    slot_req.wdata = CELL_AW'(idx_r);

    // owner from the slot read goes straight to the cell read
    cell_req            = '0;
    cell_req.en         = v1_r;
    cell_req.addr       = slot_rd_data;
    cell_req.wdata      = '{level: lev_r, value: val_r};

    acc_ctl       = '0;
    acc_ctl.add   = v2_r;

    res        = '0;
    res.query  = (op_r == OP_QUERY);
    res.status = status_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op_nxt    = in_opcode;
          idx_nxt   = in_cell_index;
          col_nxt   = in_col;
          row_nxt   = in_row;
          lev_nxt   = in_level;
          val_nxt   = in_cell_value;
          state_nxt = S_SETUP;
        end
      end
      S_SETUP: begin
        acc_ctl.clear = 1'b1;
        status_nxt    = err;
        fine_nxt      = FSIZE_W'(fine_w);
        span_m1_nxt   = FCOORD_W'(span_w - WIDE_W'(1));
        c0_nxt        = FCOORD_W'(c0_w);
        row_base_nxt  = SLOT_AW'(prod);
        col_cnt_nxt   = '0;
        row_cnt_nxt   = '0;
        if (err) begin
          state_nxt = S_FIN;
        end else begin
          if (op_r == OP_INSERT) begin
            cell_req.en   = 1'b1;
            cell_req.we   = 1'b1;
            cell_req.addr = CELL_AW'(idx_r);
          end
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        slot_req.en = 1'b1;
        slot_req.we = (op_r == OP_INSERT);
        v1_nxt      = (op_r == OP_QUERY);
        // walk the covered square row by row
        if (col_cnt_r == span_m1_r) begin
          col_cnt_nxt  = '0;
          row_base_nxt = row_base_r + SLOT_AW'(fine_r);
          if (row_cnt_r == span_m1_r) begin
            state_nxt = (op_r == OP_INSERT) ? S_FIN : S_DRAIN;
          end else begin
            row_cnt_nxt = row_cnt_r + 1'b1;
          end
        end else begin
          col_cnt_nxt = col_cnt_r + 1'b1;
        end
      end
      S_DRAIN: begin
        if (!v1_r && !v2_r) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (out_free) begin
          res.valid = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      v1_r    <= 1'b0;
      v2_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      v1_r    <= v1_nxt;
      v2_r    <= v2_nxt;
    end
    op_r       <= op_nxt;
    idx_r      <= idx_nxt;
    col_r      <= col_nxt;
    row_r      <= row_nxt;
    lev_r      <= lev_nxt;
    val_r      <= val_nxt;
    status_r   <= status_nxt;
    fine_r     <= fine_nxt;
    span_m1_r  <= span_m1_nxt;
    c0_r       <= c0_nxt;
    row_base_r <= row_base_nxt;
    col_cnt_r  <= col_cnt_nxt;
    row_cnt_r  <= row_cnt_nxt;
  end

  // The read pipeline is empty by the time a result leaves
  a_fin_drained: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIN) |-> (!v1_r && !v2_r))
    else $error("result issued with slot or cell reads in flight");

  // Every add follows a slot read, carried through v1_r and v2_r
  a_add_after_read: assert property (@(posedge clk) disable iff (!rst_n)
    v2_r |=> $past(v1_r, 2))
    else $error("accumulate without a matching slot read");

  // Slot writes only come from an insert scan
  a_slot_write_insert: assert property (@(posedge clk) disable iff (!rst_n)
    (slot_req.en && slot_req.we) |-> (state_r == S_SCAN && op_r == OP_INSERT))
    else $error("slot table written outside an insert scan");

  // Counters stay inside the covered square
  a_scan_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> (col_cnt_r <= span_m1_r && row_cnt_r <= span_m1_r))
    else $error("scan counter past the cell span");

  // No new item while the read pipeline is busy
  a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |-> (!v1_r && !v2_r))
    else $error("item accepted with reads in flight");

endmodule

`default_nettype wire

// ===== rtl/amr_hash_remap.sv =====
`default_nettype none

// Remaps cell values between two 2D adaptive meshes through a direct-mapped
// owner table over the finest grid. An insert word stores the source cell's
// value and level and writes its number into every fine slot it covers; a
// query word walks the fine slots of the target cell and sums each owner's
// value shifted right by twice the level gap, saturating at 2^33-1. Items are
// worked one at a time; a cell at level L covers span*span slots with
// span = 2^(finest_level - L), and the scan issues one table access per slot
// per cycle. A query then waits for the owner read, the cell read behind
// it and the last add to drain; a rejected item goes from setup straight
// to its result. The owner and cell tables are single-port synchronous
// memories with no reset and no clearing pass: querying a slot that no
// insert has written returns an undefined sum. A finished result sits in
// an output register, so the next word can be taken while it waits. Change
// coarse_size and finest_level only while the block is idle.
module amr_hash_remap (
  input  wire                    clk,
  input  wire                    rst_n,
  ahr_in_if.sink                 in_ch,
  ahr_out_if.source              out_ch,
  input  wire                    cfg_we,
  input  wire [0:0]              cfg_index,
  input  wire [ahr_pkg::CSIZE_W-1:0] cfg_data
);
  import ahr_pkg::*;

  csize_t     coarse_size_r;
  lev_t       finest_level_r;
  slot_req_t  slot_req;
  cell_addr_t slot_rd_data;
  cell_req_t  cell_req;
  cell_rec_t  cell_rd_data;
  acc_ctl_t   acc_ctl;
  sum_t       acc_sum;
  res_t       res;
  logic       out_free;
  logic       out_valid_r;
  sum_t       out_sum_r;
  logic       out_status_r;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coarse_size_r  <= COARSE_SIZE_RESET;
      finest_level_r <= FINEST_LEVEL_RESET;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_COARSE_SIZE:  coarse_size_r  <= cfg_data;
        REG_FINEST_LEVEL: finest_level_r <= cfg_data[LEV_W-1:0];
        default: ;
      endcase
    end
  end

  ahr_ctrl u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .coarse_size   (coarse_size_r),
    .finest_level  (finest_level_r),
    .in_valid      (in_ch.valid),
    .in_ready      (in_ch.ready),
    .in_opcode     (in_ch.opcode),
    .in_cell_index (in_ch.cell_index),
    .in_col        (in_ch.col),
    .in_row        (in_ch.row),
    .in_level      (in_ch.level),
    .in_cell_value (in_ch.cell_value),
    .slot_req      (slot_req),
    .slot_rd_data  (slot_rd_data),
    .cell_req      (cell_req),
    .acc_ctl       (acc_ctl),
    .out_free      (out_free),
    .res           (res)
  );

  ahr_slot_table u_slot_table (
    .clk     (clk),
    .req     (slot_req),
    .rd_data (slot_rd_data)
  );

  ahr_cell_store u_cell_store (
    .clk     (clk),
    .req     (cell_req),
    .rd_data (cell_rd_data)
  );

  ahr_accum u_accum (
    .clk          (clk),
    .ctl          (acc_ctl),
    .finest_level (finest_level_r),
    .rec          (cell_rd_data),
    .sum          (acc_sum)
  );

  // Output register: load a finished result, drop it when taken
  assign out_free = !out_valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res.valid) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
    if (res.valid) begin
      out_sum_r    <= (res.query && !res.status) ? acc_sum : '0;
      out_status_r <= res.status;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.remapped_sum = out_sum_r;
  assign out_ch.status       = out_status_r;

endmodule

`default_nettype wire
